// ----- sv/cba_pkg.sv -----
package cba_pkg;

	// field widths fixed by the request and result formats
	localparam int IDX_W    = 12;
	localparam int COUNT_W  = 13;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic                clr_step;
		logic                load;
		logic                scan_step;
		logic                seek_step;
		logic                wr_alloc;
		logic                wr_free;
		logic                emit;
		logic [STATUS_W-1:0] res_status;
		logic                res_alloc;
		logic                res_query;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic              clr_last;
		logic              out_free;
		logic              idx_range;
		logic              found;
		logic              last_word;
		logic              seek_hit;
		logic [KIND_W-1:0] kind;
	} dp_stat_t;

endpackage

// ----- sv/cba_ram.sv -----
module cba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/cba_ctrl.sv -----
module cba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cba_pkg::dp_stat_t stat,
	output cba_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SEEK = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.kind == cba_pkg::KIND_ALLOC) begin
					state_d = S_SCAN;
				end else if ((stat.kind == cba_pkg::KIND_FREE ||
						stat.kind == cba_pkg::KIND_QUERY) && !stat.idx_range) begin
					state_d = S_SEEK;
				end else if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.res_status = cba_pkg::ST_RANGE;
					state_d        = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.found) begin
					if (stat.out_free) begin
						cmd.wr_alloc   = 1'b1;
						cmd.emit       = 1'b1;
						cmd.res_status = cba_pkg::ST_OK;
						cmd.res_alloc  = 1'b1;
						state_d        = S_IDLE;
					end
				end else if (stat.last_word) begin
					if (stat.out_free) begin
						cmd.emit       = 1'b1;
						cmd.res_status = cba_pkg::ST_FULL;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SEEK: begin
				if (stat.seek_hit) begin
					if (stat.out_free) begin
						cmd.emit       = 1'b1;
						cmd.res_status = cba_pkg::ST_OK;
						if (stat.kind == cba_pkg::KIND_FREE) begin
							cmd.wr_free = 1'b1;
						end else begin
							cmd.res_query = 1'b1;
						end
						state_d = S_IDLE;
					end
				end else begin
					cmd.seek_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/cba_datapath.sv -----
module cba_datapath #(
	parameter int MAX_CLUSTERS = 4096,
	parameter int WORD_BITS    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [cba_pkg::COUNT_W-1:0]  cfg_data,
	input  logic [cba_pkg::KIND_W-1:0]   in_kind,
	input  logic [cba_pkg::IDX_W-1:0]    in_index,
	input  cba_pkg::dp_cmd_t             cmd,
	output cba_pkg::dp_stat_t            stat,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cba_pkg::STATUS_W-1:0] m_status,
	output logic [cba_pkg::IDX_W-1:0]    m_index,
	output logic                         m_is_free
);

	localparam int MAP_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CW        = cba_pkg::COUNT_W;
	localparam int IW        = cba_pkg::IDX_W;
	localparam int CNT_MAX   = (1 << CW) - 1;
	localparam int CAP       = MAX_CLUSTERS > CNT_MAX ? CNT_MAX : MAX_CLUSTERS;

	logic [CW-1:0]                  cnt_q;
	logic [AW-1:0]                  clr_q;
	logic [AW-1:0]                  ptr_q;
	logic [AW-1:0]                  ptr_d;
	logic [CW-1:0]                  rem_q;
	logic [CW-1:0]                  base_q;
	logic [IW-1:0]                  tgt_q;
	logic [cba_pkg::KIND_W-1:0]     kind_q;
	logic                           out_valid_q;
	logic [cba_pkg::STATUS_W-1:0]   out_status_q;
	logic [IW-1:0]                  out_index_q;
	logic                           out_free_q;
	logic [CW-1:0]                  cnt_live;
	logic [WORD_BITS-1:0]           rdata;
	logic [WORD_BITS-1:0]           lim_mask;
	logic [WORD_BITS-1:0]           open_bits;
	logic [WORD_BITS-1:0]           pick;
	logic [BW-1:0]                  pick_pos;
	logic [CW-1:0]                  alloc_sum;
	logic [WORD_BITS-1:0]           free_mask;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [WORD_BITS-1:0]           ram_wdata;

	// count above the pool acts as the pool size
	assign cnt_live = (cnt_q > CW'(CAP)) ? CW'(CAP) : cnt_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= cba_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// word pointer: read address runs on the next value so data matches ptr_q
	always_comb begin
		priority if (cmd.load) begin
			ptr_d = '0;
		end else if (cmd.scan_step || cmd.seek_step) begin
			ptr_d = ptr_q + AW'(1);
		end else begin
			ptr_d = ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_d;
		end
	end

	// request and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			tgt_q  <= in_index;
			rem_q  <= cnt_live;
			base_q <= '0;
		end else if (cmd.scan_step) begin
			rem_q  <= rem_q - CW'(WORD_BITS);
			base_q <= base_q + CW'(WORD_BITS);
		end else if (cmd.seek_step) begin
			tgt_q <= tgt_q - IW'(WORD_BITS);
		end
	end

	// free bits of the current word that lie below the count
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			lim_mask[b] = CW'(b) < rem_q;
		end
	end

	assign open_bits = ~rdata & lim_mask;
	assign pick      = open_bits & (~open_bits + {{(WORD_BITS-1){1'b0}}, 1'b1});

	// encode the isolated lowest free bit
	always_comb begin
		pick_pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (pick[b]) begin
				pick_pos = pick_pos | BW'(b);
			end
		end
	end

	assign alloc_sum = base_q + CW'(pick_pos);
	assign free_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << tgt_q[BW-1:0];

	// bitmap write port
	always_comb begin
		ram_we    = cmd.clr_step || cmd.wr_alloc || cmd.wr_free;
		ram_waddr = cmd.clr_step ? clr_q : ptr_q;
		priority if (cmd.clr_step) begin
			ram_wdata = '0;
		end else if (cmd.wr_alloc) begin
			ram_wdata = rdata | pick;
		end else begin
			ram_wdata = rdata & ~free_mask;
		end
	end

	cba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_d),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.res_status;
			out_index_q  <= cmd.res_alloc ? alloc_sum[IW-1:0] : '0;
			out_free_q   <= cmd.res_query ? ~rdata[tgt_q[BW-1:0]] : 1'b0;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_status  = out_status_q;
	assign m_index   = out_index_q;
	assign m_is_free = out_free_q;

	// status toward the controller
	always_comb begin
		stat.clr_last  = clr_q == AW'(MAP_WORDS - 1);
		stat.out_free  = !out_valid_q || m_tready;
		stat.idx_range = CW'(tgt_q) >= cnt_live;
		stat.found     = |open_bits;
		stat.last_word = rem_q <= CW'(WORD_BITS);
		stat.seek_hit  = tgt_q < IW'(WORD_BITS);
		stat.kind      = kind_q;
	end

endmodule

// ----- sv/cluster_bitmap_allocator_core.sv -----
// channel   dir  signals                       contents
// s_*       in   s_tvalid s_tready s_tdata      tdata[11:0] cluster_index, tuser[1:0] kind
//                s_tuser
// m_*       out  m_tvalid m_tready m_tdata      tdata[11:0] allocated_index, tdata[12] is_free,
//                m_tuser                        tuser[1:0] status
// cfg_*     in   cfg_valid cfg_ready cfg_data   cfg_data[12:0] cluster_count
//
// one request at a time; the bitmap RAM reads one word per cycle
// allocate: the scan reads words in order from word 0 up to the word holding the hit
// free and query: the seek steps to word cluster_index / WORD_BITS; range errors skip the seek
// after reset a clearing pass writes MAP_WORDS words (128 by default), s_tready low
// a result waits in the output register; the next request is taken meanwhile
module cluster_bitmap_allocator_core #(
	parameter int MAX_CLUSTERS = 4096,
	parameter int WORD_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] cluster_index, [15:12] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] allocated_index, [12] is_free, [15:13] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data   // [12:0] cluster_count
);

	cba_pkg::dp_cmd_t             cmd;
	cba_pkg::dp_stat_t            stat;
	logic [cba_pkg::IDX_W-1:0]    res_index;
	logic                         res_free;
	logic [cba_pkg::STATUS_W-1:0] res_status;

	assign cfg_ready = 1'b1;

	cba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cba_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.WORD_BITS    (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_index  (s_tdata[11:0]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_status  (res_status),
		.m_index   (res_index),
		.m_is_free (res_free)
	);

	// pack result fields
	assign m_tdata = {3'b000, res_free, res_index};
	assign m_tuser = res_status;

	// a new result never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result emitted while previous result still pending");

	// an emitted result shows up on the output next cycle
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted result not presented");

	// only one request in flight
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// allocation writes only when a free bit was found
	a_alloc_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> (stat.found && stat.kind == cba_pkg::KIND_ALLOC))
		else $error("allocation write without a free cluster");

endmodule
